>>> hw/rtl/isp_pkg.sv
// Shared types, constants and helper functions for the integer stream profiler.
package isp_pkg;

  localparam int COUNT_BITS = 24;
  localparam int OUT_W      = 24;
  localparam int ELEM_W     = 64;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [OUT_W-1:0]      OUT_MAX = {OUT_W{1'b1}};

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_WIDTH_CODE  = 2'd0,
    REG_SIGNED_MODE = 2'd1,
    REG_MSB_FIRST   = 2'd2
  } reg_idx_t;

  // Element width codes.
  typedef enum logic [1:0] {
    WIDTH_1B = 2'd0,
    WIDTH_2B = 2'd1,
    WIDTH_4B = 2'd2,
    WIDTH_8B = 2'd3
  } width_code_t;

  typedef struct packed {
    logic [1:0] width_code;
    logic       signed_mode;
    logic       msb_first;
  } cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0]  element_count;
    logic [OUT_W-1:0]  zero_count;
    logic [OUT_W-1:0]  pair_count;
    logic [OUT_W-1:0]  rising_count;
    logic [OUT_W-1:0]  falling_count;
    logic [OUT_W-1:0]  run_count;
    logic [OUT_W-1:0]  longest_run;
    logic [ELEM_W-1:0] min_ordered;
    logic [ELEM_W-1:0] max_ordered;
    logic [ELEM_W-1:0] abs_delta;
    logic              delta_valid;
  } result_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Clamp a counter to the output width; works for counters narrower or wider.
  function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] lim;
    lim = COUNT_BITS'(OUT_MAX);
    clamp_out = (v > lim) ? OUT_MAX : OUT_W'(v);
  endfunction

endpackage

>>> hw/rtl/isp_if.sv
// Stream interfaces for the profiler's input items and result items.
interface isp_in_if;
  import isp_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ELEM_W-1:0] element_bytes;
  logic              window_start;

  modport source (output valid, cmd, element_bytes, window_start, input ready);
  modport sink   (input valid, cmd, element_bytes, window_start, output ready);
endinterface

interface isp_out_if;
  import isp_pkg::*;
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  element_count;
  logic [OUT_W-1:0]  zero_count;
  logic [OUT_W-1:0]  pair_count;
  logic [OUT_W-1:0]  rising_count;
  logic [OUT_W-1:0]  falling_count;
  logic [OUT_W-1:0]  run_count;
  logic [OUT_W-1:0]  longest_run;
  logic [ELEM_W-1:0] min_ordered;
  logic [ELEM_W-1:0] max_ordered;
  logic [ELEM_W-1:0] abs_delta;
  logic              delta_valid;

  modport source (output valid, element_count, zero_count, pair_count, rising_count,
                  falling_count, run_count, longest_run, min_ordered, max_ordered,
                  abs_delta, delta_valid, input ready);
  modport sink   (input valid, element_count, zero_count, pair_count, rising_count,
                  falling_count, run_count, longest_run, min_ordered, max_ordered,
                  abs_delta, delta_valid, output ready);
endinterface

>>> hw/rtl/integer_stream_profiler_core.sv
// Top level of the integer stream profiler: input register, datapath and result handshake.
// Each result passes the input register, then the result register. Throughput: one element
// per cycle while results are taken; the input register and the result register form a
// two-stage pipeline, and statistics update in the second stage.
// Reset (synchronous, active high) clears all statistics, the window-open flag,
// the configuration registers and both pipeline valid flags.
module integer_stream_profiler_core (
  input  logic                        clk,
  input  logic                        rst,
  isp_in_if.sink                      items,
  isp_out_if.source                   results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [isp_pkg::ADDR_W-1:0]  paddr,
  input  logic [isp_pkg::DATA_W-1:0]  pwdata,
  output logic [isp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import isp_pkg::*;

  cfg_t              cfg;
  result_t           result;
  logic              in_valid;
  logic              in_cmd;
  logic              in_window_start;
  logic [ELEM_W-1:0] in_bytes;
  logic              out_valid;
  logic              advance;
  logic              load;
  logic [ELEM_W-1:0] ordered;
  logic              is_zero;

  // The result register frees up whenever it is empty or being taken.
  assign advance     = !out_valid || results.ready;
  assign load        = in_valid && advance;
  assign items.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (items.ready) in_valid <= items.valid;
      if (advance) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_cmd          <= items.cmd;
      in_window_start <= items.window_start;
      in_bytes        <= items.element_bytes;
    end
  end

  isp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  isp_order u_order (
    .cfg           (cfg),
    .element_bytes (in_bytes),
    .ordered       (ordered),
    .is_zero       (is_zero)
  );

  isp_stats u_stats (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .cmd          (in_cmd),
    .window_start (in_window_start),
    .ordered      (ordered),
    .is_zero      (is_zero),
    .result       (result)
  );

  assign results.valid         = out_valid;
  assign results.element_count = result.element_count;
  assign results.zero_count    = result.zero_count;
  assign results.pair_count    = result.pair_count;
  assign results.rising_count  = result.rising_count;
  assign results.falling_count = result.falling_count;
  assign results.run_count     = result.run_count;
  assign results.longest_run   = result.longest_run;
  assign results.min_ordered   = result.min_ordered;
  assign results.max_ordered   = result.max_ordered;
  assign results.abs_delta     = result.abs_delta;
  assign results.delta_valid   = result.delta_valid;

  a_load_fills_out: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("result register not filled after load");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_bytes) && $stable(in_cmd))
    else $error("input register changed while stalled");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> items.ready)
    else $error("empty input register refused a transaction");

endmodule

>>> hw/rtl/isp_cfg.sv
// APB register file holding element width, signedness and byte order.
module isp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [isp_pkg::ADDR_W-1:0]  paddr,
  input  logic [isp_pkg::DATA_W-1:0]  pwdata,
  output logic [isp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output isp_pkg::cfg_t               cfg
);
  import isp_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH_CODE:  cfg.width_code  <= pwdata[1:0];
        REG_SIGNED_MODE: cfg.signed_mode <= pwdata[0];
        REG_MSB_FIRST:   cfg.msb_first   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_WIDTH_CODE:  prdata = DATA_W'(cfg.width_code);
      REG_SIGNED_MODE: prdata = DATA_W'(cfg.signed_mode);
      REG_MSB_FIRST:   prdata = DATA_W'(cfg.msb_first);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/isp_order.sv
// Assembles an element from its stream bytes and maps it to an ordered value.
module isp_order (
  input  isp_pkg::cfg_t               cfg,
  input  logic [isp_pkg::ELEM_W-1:0]  element_bytes,
  output logic [isp_pkg::ELEM_W-1:0]  ordered,
  output logic                        is_zero
);
  import isp_pkg::*;

  logic [ELEM_W-1:0] rev;
  logic [ELEM_W-1:0] mask;
  logic [ELEM_W-1:0] sign_bit;
  logic [5:0]        shamt;
  logic [ELEM_W-1:0] bits;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      rev[8*j +: 8] = element_bytes[8*(7-j) +: 8];
    end
    unique case (width_code_t'(cfg.width_code))
      WIDTH_1B: begin
        mask = 64'h0000_0000_0000_00FF; sign_bit = 64'h0000_0000_0000_0080; shamt = 6'd56;
      end
      WIDTH_2B: begin
        mask = 64'h0000_0000_0000_FFFF; sign_bit = 64'h0000_0000_0000_8000; shamt = 6'd48;
      end
      WIDTH_4B: begin
        mask = 64'h0000_0000_FFFF_FFFF; sign_bit = 64'h0000_0000_8000_0000; shamt = 6'd32;
      end
      WIDTH_8B: begin
        mask = 64'hFFFF_FFFF_FFFF_FFFF; sign_bit = 64'h8000_0000_0000_0000; shamt = 6'd0;
      end
      default: begin
        mask = '1; sign_bit = '0; shamt = 6'd0;
      end
    endcase
    // Reversing all eight bytes and shifting down leaves stream byte 0 on top.
    bits    = cfg.msb_first ? (rev >> shamt) : (element_bytes & mask);
    is_zero = (bits == '0);
    ordered = cfg.signed_mode ? (bits ^ sign_bit) : bits;
  end

endmodule

>>> hw/rtl/isp_stats.sv
// Running statistics state and the result register.
module isp_stats (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        cmd,
  input  logic                        window_start,
  input  logic [isp_pkg::ELEM_W-1:0]  ordered,
  input  logic                        is_zero,
  output isp_pkg::result_t            result
);
  import isp_pkg::*;

  logic [ELEM_W-1:0]     previous_ordered, previous_ordered_next;
  logic [COUNT_BITS-1:0] current_run, current_run_next;
  logic [COUNT_BITS-1:0] count_elements, count_elements_next;
  logic [COUNT_BITS-1:0] count_zeros, count_zeros_next;
  logic [COUNT_BITS-1:0] count_pairs, count_pairs_next;
  logic [COUNT_BITS-1:0] count_rising, count_rising_next;
  logic [COUNT_BITS-1:0] count_falling, count_falling_next;
  logic [COUNT_BITS-1:0] count_runs, count_runs_next;
  logic [COUNT_BITS-1:0] best_run, best_run_next;
  logic [ELEM_W-1:0]     low_mark, low_mark_next;
  logic [ELEM_W-1:0]     high_mark, high_mark_next;
  logic                  window_open, window_open_next;

  logic                  start, ge, le;
  logic [ELEM_W-1:0]     diff, delta;
  logic                  dvalid;
  logic [COUNT_BITS-1:0] run_step;

  always_comb begin
    start    = window_start || !window_open;
    ge       = ordered >= previous_ordered;
    le       = ordered <= previous_ordered;
    diff     = ge ? (ordered - previous_ordered) : (previous_ordered - ordered);
    run_step = (start || (ordered != previous_ordered)) ? COUNT_BITS'(1) : sat_inc(current_run);

    previous_ordered_next = previous_ordered;
    current_run_next      = current_run;
    count_elements_next   = count_elements;
    count_zeros_next      = count_zeros;
    count_pairs_next      = count_pairs;
    count_rising_next     = count_rising;
    count_falling_next    = count_falling;
    count_runs_next       = count_runs;
    best_run_next         = best_run;
    low_mark_next         = low_mark;
    high_mark_next        = high_mark;
    window_open_next      = window_open;
    delta                 = '0;
    dvalid                = 1'b0;

    if (cmd) begin
      previous_ordered_next = '0;
      current_run_next      = '0;
      count_elements_next   = '0;
      count_zeros_next      = '0;
      count_pairs_next      = '0;
      count_rising_next     = '0;
      count_falling_next    = '0;
      count_runs_next       = '0;
      best_run_next         = '0;
      low_mark_next         = '1;
      high_mark_next        = '0;
      window_open_next      = 1'b0;
    end else begin
      count_elements_next = sat_inc(count_elements);
      if (is_zero) count_zeros_next = sat_inc(count_zeros);
      if (ordered < low_mark) low_mark_next = ordered;
      if (ordered > high_mark) high_mark_next = ordered;
      if (!start) begin
        count_pairs_next = sat_inc(count_pairs);
        if (ge) count_rising_next = sat_inc(count_rising);
        if (le) count_falling_next = sat_inc(count_falling);
        delta  = diff;
        dvalid = 1'b1;
      end
      if (start || (ordered != previous_ordered)) count_runs_next = sat_inc(count_runs);
      current_run_next      = run_step;
      best_run_next         = (run_step > best_run) ? run_step : best_run;
      previous_ordered_next = ordered;
      window_open_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_ordered <= '0;
      current_run      <= '0;
      count_elements   <= '0;
      count_zeros      <= '0;
      count_pairs      <= '0;
      count_rising     <= '0;
      count_falling    <= '0;
      count_runs       <= '0;
      best_run         <= '0;
      low_mark         <= '1;
      high_mark        <= '0;
      window_open      <= 1'b0;
    end else if (load) begin
      previous_ordered <= previous_ordered_next;
      current_run      <= current_run_next;
      count_elements   <= count_elements_next;
      count_zeros      <= count_zeros_next;
      count_pairs      <= count_pairs_next;
      count_rising     <= count_rising_next;
      count_falling    <= count_falling_next;
      count_runs       <= count_runs_next;
      best_run         <= best_run_next;
      low_mark         <= low_mark_next;
      high_mark        <= high_mark_next;
      window_open      <= window_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.element_count <= clamp_out(count_elements_next);
      result.zero_count    <= clamp_out(count_zeros_next);
      result.pair_count    <= clamp_out(count_pairs_next);
      result.rising_count  <= clamp_out(count_rising_next);
      result.falling_count <= clamp_out(count_falling_next);
      result.run_count     <= clamp_out(count_runs_next);
      result.longest_run   <= clamp_out(best_run_next);
      result.min_ordered   <= low_mark_next;
      result.max_ordered   <= high_mark_next;
      result.abs_delta     <= delta;
      result.delta_valid   <= dvalid;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    load && cmd |=> (count_elements == '0) && !window_open)
    else $error("clear transaction left statistics behind");

  a_best_covers_run: assert property (@(posedge clk) disable iff (rst)
    best_run >= current_run)
    else $error("longest run below current run");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (count_elements != '0) |-> (low_mark <= high_mark))
    else $error("minimum above maximum after elements seen");

  a_runs_bounded: assert property (@(posedge clk) disable iff (rst)
    (count_runs <= count_elements) && (count_pairs <= count_elements))
    else $error("run or pair count exceeds element count");

  a_open_has_run: assert property (@(posedge clk) disable iff (rst)
    window_open |-> (current_run != '0) && (count_elements != '0))
    else $error("open window without a run");

endmodule
